FILE: rtl/core/sfrt_pkg.sv
// Shared types and constants for the SPI frame receiver with timeouts.
// No dependencies; imported by the sample queue, frame engine and top level.
`default_nettype none

package sfrt_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 24;
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 2;
    localparam int FIELD_W   = 3;

    localparam logic [COUNT_W-1:0] WAIT_TIMEOUT_RST = 24'd48000;
    localparam logic [COUNT_W-1:0] GAP_LIMIT_RST    = 24'd24000;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT    = 1'd1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GAP_LONG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CS_TIMEOUT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLK_TIMEOUT = 2'd3;

    typedef struct packed {
        logic chip_select;
        logic serial_clock;
        logic serial_data;
        logic command_select;
    } t_sample;

    typedef struct packed {
        logic [BYTE_W-1:0]   frame_byte;
        logic                command_flag;
        logic [FIELD_W-1:0]  command_code;
        logic [FIELD_W-1:0]  command_arg;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/sfrt_sample_queue.sv
// Two-entry queue of pin samples between the input channel and the frame engine.
// Depends on sfrt_pkg for the sample type.
`default_nettype none

module sfrt_sample_queue
    import sfrt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_sample i_sample,
    output logic         o_ready,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_sample      o_sample
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sample            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_ready  = (r_count != CNT_W'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_sample = r_mem[r_rd];
    assign push     = i_valid && o_ready;
    assign pop      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sfrt_frame_engine.sv
// Frame engine: chip-select hunt, clock edge shifting, wait and gap timeouts,
// configuration registers and the output register. Depends on sfrt_pkg.
`default_nettype none

module sfrt_frame_engine
    import sfrt_pkg::*;
#(
    parameter int FRAME_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COUNT_W-1:0]   i_cfg_data,
    input  wire logic                 i_sample_valid,
    input  wire t_sample              i_sample,
    output logic                      o_pop,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output t_result                   o_result
);

    localparam int BITS_W = $clog2(FRAME_BITS + 1);

    typedef enum logic [1:0] {
        PH_CS_HIGH,
        PH_CS_LOW,
        PH_CLK_LOW,
        PH_CLK_HIGH
    } t_phase;

    logic [COUNT_W-1:0] r_wait_timeout;
    logic [COUNT_W-1:0] r_gap_limit;

    t_phase             r_phase,  n_phase;
    logic [BYTE_W-1:0]  r_shift,  n_shift;
    logic [BITS_W-1:0]  r_bits,   n_bits;
    logic [COUNT_W-1:0] r_wait,   n_wait;
    logic [COUNT_W-1:0] r_gap,    n_gap;
    logic               r_first,  n_first;
    logic               r_out_valid;
    t_result            r_result, n_result;
    logic               n_emit;

    logic               fire;
    logic               in_clk;
    logic [COUNT_W:0]   elapsed;
    logic [COUNT_W:0]   gap;
    logic [BYTE_W-1:0]  shifted;
    logic [BITS_W-1:0]  bits_inc;

    assign fire        = i_sample_valid && (!r_out_valid || i_out_ready);
    assign o_pop       = fire;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign in_clk   = (r_phase == PH_CLK_LOW) || (r_phase == PH_CLK_HIGH);
    assign elapsed  = {1'b0, r_wait} + 1'b1;
    assign gap      = {1'b0, r_gap} + 1'b1;
    assign shifted  = {r_shift[BYTE_W-2:0], i_sample.serial_data};
    assign bits_inc = r_bits + 1'b1;

    function automatic logic [COUNT_W-1:0] sat24(input logic [COUNT_W:0] v);
        sat24 = v[COUNT_W] ? '1 : v[COUNT_W-1:0];
    endfunction

    function automatic t_result pack_result(input logic [BYTE_W-1:0]   b,
                                            input logic                cmd,
                                            input logic [STATUS_W-1:0] st);
        t_result r;
        r.frame_byte   = b;
        r.command_flag = cmd;
        r.command_code = b[BYTE_W-1 -: FIELD_W];
        r.command_arg  = b[FIELD_W-1:0];
        r.status       = st;
        pack_result    = r;
    endfunction

    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_wait   = r_wait;
        n_gap    = r_gap;
        n_first  = r_first;
        n_result = r_result;
        n_emit   = 1'b0;

        if (r_first && in_clk) begin
            n_gap = sat24(gap);
        end

        if (elapsed > {1'b0, r_wait_timeout}) begin
            n_emit   = 1'b1;
            n_result = pack_result(r_shift, 1'b0, in_clk ? ST_CLK_TIMEOUT : ST_CS_TIMEOUT);
        end else begin
            n_wait = sat24(elapsed);
            case (r_phase)
                PH_CS_HIGH: begin
                    if (i_sample.chip_select) begin
                        n_phase = PH_CS_LOW;
                    end
                end
                PH_CS_LOW: begin
                    if (!i_sample.chip_select) begin
                        n_phase = PH_CLK_LOW;
                        n_wait  = '0;
                        n_shift = '0;
                        n_bits  = '0;
                        n_gap   = '0;
                        n_first = 1'b0;
                    end
                end
                PH_CLK_LOW: begin
                    if (!i_sample.serial_clock) begin
                        n_phase = PH_CLK_HIGH;
                    end
                end
                PH_CLK_HIGH: begin
                    if (i_sample.serial_clock) begin
                        n_shift = shifted;
                        n_bits  = bits_inc;
                        n_first = 1'b1;
                        n_gap   = '0;
                        n_wait  = '0;
                        n_phase = PH_CLK_LOW;
                        if (r_first && (gap >= {1'b0, r_gap_limit})) begin
                            n_emit   = 1'b1;
                            n_result = pack_result(shifted, 1'b0, ST_GAP_LONG);
                        end else if (bits_inc >= BITS_W'(FRAME_BITS)) begin
                            n_emit   = 1'b1;
                            n_result = pack_result(shifted, i_sample.command_select, ST_OK);
                        end
                    end
                end
                default: begin
                    n_phase = PH_CS_HIGH;
                end
            endcase
        end

        if (n_emit) begin
            n_phase = PH_CS_HIGH;
            n_shift = '0;
            n_bits  = '0;
            n_wait  = '0;
            n_gap   = '0;
            n_first = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_timeout <= WAIT_TIMEOUT_RST;
            r_gap_limit    <= GAP_LIMIT_RST;
            r_phase        <= PH_CS_HIGH;
            r_shift        <= '0;
            r_bits         <= '0;
            r_wait         <= '0;
            r_gap          <= '0;
            r_first        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WAIT_TIMEOUT: r_wait_timeout <= i_cfg_data;
                    CFG_GAP_LIMIT:    r_gap_limit    <= i_cfg_data;
                    default:          r_gap_limit    <= r_gap_limit;
                endcase
            end
            if (fire) begin
                r_phase <= n_phase;
                r_shift <= n_shift;
                r_bits  <= n_bits;
                r_wait  <= n_wait;
                r_gap   <= n_gap;
                r_first <= n_first;
            end
            if (fire && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fire && n_emit) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spi_frame_receiver_with_timeouts_top.sv
// SPI frame receiver with timeouts, top level.
// Depends on sfrt_pkg, sfrt_sample_queue and sfrt_frame_engine.
//
// Usage:
//   Input channel: one beat per tick carries the sampled chip select (active
//   low), serial clock, data and command/data pins. Output channel: one beat
//   per finished frame or error, with the byte, its kind, the command
//   code/argument split and a status (ok, gap too long, chip-select timeout,
//   clock timeout). Every error restarts the hunt for chip select.
//   Config port: i_cfg_index 0 = wait timeout, 1 = clock gap limit, written
//   when i_cfg_we is high; take effect on the next sample processed.
//   Output: a result beat, if any, is registered as the engine takes the
//   sample from the queue. Throughput: one sample per cycle while no result
//   beat is held waiting for i_out_ready.
//   Reset: synchronous, active low; restores the default limits (48000 and
//   24000 ticks), restarts the chip-select hunt, drops all queued samples.
//   Stall: while a result beat is not taken the engine holds; the two-entry
//   sample queue fills up, then o_in_ready goes low.
`default_nettype none

module spi_frame_receiver_with_timeouts_top
    import sfrt_pkg::*;
#(
    parameter int FRAME_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COUNT_W-1:0]   i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_chip_select,
    input  wire logic                 i_serial_clock,
    input  wire logic                 i_serial_data,
    input  wire logic                 i_command_select,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [BYTE_W-1:0]         o_frame_byte,
    output logic                      o_command_flag,
    output logic [FIELD_W-1:0]        o_command_code,
    output logic [FIELD_W-1:0]        o_command_arg,
    output logic [STATUS_W-1:0]       o_status
);

    t_sample in_sample;
    t_sample q_sample;
    logic    q_valid;
    logic    q_pop;
    t_result result;

    assign in_sample.chip_select    = i_chip_select;
    assign in_sample.serial_clock   = i_serial_clock;
    assign in_sample.serial_data    = i_serial_data;
    assign in_sample.command_select = i_command_select;

    sfrt_sample_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_sample (in_sample),
        .o_ready  (o_in_ready),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_sample (q_sample)
    );

    sfrt_frame_engine #(
        .FRAME_BITS (FRAME_BITS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (q_valid),
        .i_sample       (q_sample),
        .o_pop          (q_pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_result       (result)
    );

    assign o_frame_byte   = result.frame_byte;
    assign o_command_flag = result.command_flag;
    assign o_command_code = result.command_code;
    assign o_command_arg  = result.command_arg;
    assign o_status       = result.status;

    a_error_not_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> !o_command_flag)
        else $error("error beat flagged as command");

    a_fields_match_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_command_code == o_frame_byte[7:5])
                         && (o_command_arg == o_frame_byte[2:0])))
        else $error("command fields disagree with byte");

    a_clean_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (o_in_ready && !o_out_valid))
        else $error("state not clear after reset");

endmodule

`default_nettype wire
